// ===== sv/frc_pkg.sv =====
// frc_pkg: shared widths, class codes and sequencer states for the
// fraction reduce and classify block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [1:0] {
		CLASS_NORMAL = 2'd0,
		CLASS_NAN    = 2'd1,
		CLASS_INF    = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD_CHECK,
		ST_GCD_WAIT,
		ST_DIVN_GO,
		ST_DIVN_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT
	} state_t;

	function automatic class_t classify(input word_t top, input word_t bottom);
		class_t c;
		if (bottom != '0) c = CLASS_NORMAL;
		else if (top == '0) c = CLASS_NAN;
		else c = CLASS_INF;
		return c;
	endfunction

	function automatic word_t negate_if(input word_t v, input logic neg);
		word_t r;
		r = neg ? (~v + word_t'(1)) : v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fraction_reduce_classify.sv =====
// fraction_reduce_classify: reduces a signed fraction by the gcd of the magnitudes
// and classifies it and its reciprocal. Depends on frc_pkg and frc_div.
// The gcd takes k Euclid remainder steps (k up to 45 at 32 bits); each step and
// each final division runs on one shared bit-serial divider. One request at a
// time: busy is high from accept until done. done is a one-cycle strobe; the
// receiver cannot stall. Reset clears the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fraction_reduce_classify import frc_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	output logic         busy,
	input  word_t        numerator,
	input  word_t        denominator,
	output logic         done,
	output word_t        reduced_num,
	output word_t        reduced_den,
	output logic [1:0]   value_class,
	output word_t        recip_num,
	output word_t        recip_den,
	output logic [1:0]   recip_class
);

	state_t state_q, state_d;
	word_t  x_q, y_q, nmag_q, dmag_q, rn_q;
	logic   nneg_q, dneg_q;
	logic   done_q;
	word_t  rd_q, rnum_q;
	class_t vcls_q, rcls_q;

	logic   div_go;
	word_t  div_a, div_b;
	logic   div_done;
	word_t  div_quot, div_rem;

	word_t  n_in, d_in, t_val;

	assign n_in  = numerator;
	assign d_in  = denominator;
	assign t_val = (x_q == '0) ? word_t'(1) : x_q;

	frc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DIVD_WAIT) && div_done;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		div_a   = x_q;
		div_b   = y_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_GCD_CHECK;
			end
			ST_GCD_CHECK: begin
				if (y_q != '0) begin
					div_go  = 1'b1;
					state_d = ST_GCD_WAIT;
				end else begin
					state_d = ST_DIVN_GO;
				end
			end
			ST_GCD_WAIT: begin
				if (div_done) state_d = ST_GCD_CHECK;
			end
			ST_DIVN_GO: begin
				div_go  = 1'b1;
				div_a   = nmag_q;
				div_b   = x_q;
				state_d = ST_DIVN_WAIT;
			end
			ST_DIVN_WAIT: begin
				if (div_done) state_d = ST_DIVD_GO;
			end
			ST_DIVD_GO: begin
				div_go  = 1'b1;
				div_a   = dmag_q;
				div_b   = x_q;
				state_d = ST_DIVD_WAIT;
			end
			ST_DIVD_WAIT: begin
				if (div_done) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					nneg_q <= n_in[DATA_WIDTH-1];
					dneg_q <= d_in[DATA_WIDTH-1];
					nmag_q <= negate_if(n_in, n_in[DATA_WIDTH-1]);
					dmag_q <= negate_if(d_in, d_in[DATA_WIDTH-1]);
					x_q    <= negate_if(n_in, n_in[DATA_WIDTH-1]);
					y_q    <= negate_if(d_in, d_in[DATA_WIDTH-1]);
				end
			end
			ST_GCD_CHECK: begin
				// zero gcd only when both are zero
				if (y_q == '0) x_q <= t_val;
			end
			ST_GCD_WAIT: begin
				if (div_done) begin
					x_q <= y_q;
					y_q <= div_rem;
				end
			end
			ST_DIVN_WAIT: begin
				if (div_done) rn_q <= negate_if(div_quot, nneg_q);
			end
			ST_DIVD_WAIT: begin
				if (div_done) begin
					rd_q   <= negate_if(div_quot, dneg_q);
					rnum_q <= rn_q;
					vcls_q <= classify(nmag_q, dmag_q);
					rcls_q <= classify(dmag_q, nmag_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign reduced_num = rnum_q;
	assign reduced_den = rd_q;
	assign value_class = vcls_q;
	assign recip_num   = rd_q;
	assign recip_den   = rnum_q;
	assign recip_class = rcls_q;

endmodule

`default_nettype wire

// ===== sv/frc_div.sv =====
// frc_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on frc_pkg. Divisor must be nonzero.
`timescale 1ns / 1ps
`default_nettype none

module frc_div import frc_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   go,
	input  word_t dividend,
	input  word_t divisor,
	output logic  done,
	output word_t quotient,
	output word_t remainder
);

	logic                  run_q;
	logic                  done_q;
	cnt_t                  cnt_q;
	word_t                 rem_q;
	word_t                 quot_q;
	word_t                 dvs_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;

	assign trial = {rem_q, quot_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= cnt_t'(DATA_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - cnt_t'(1);
				if (cnt_q == cnt_t'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (run_q) begin
			if (!diff[DATA_WIDTH]) begin
				rem_q  <= diff[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== sv/frc_check.sv =====
// frc_check: port-level checks for fraction_reduce_classify, bound to the top level.
// Depends on frc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frc_check import frc_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input word_t      reduced_num,
	input word_t      reduced_den,
	input wire [1:0]  value_class,
	input word_t      recip_num,
	input word_t      recip_den,
	input wire [1:0]  recip_class
);

	// accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done strobe outside a request");

	a_nan_both: assert property (@(posedge clk) disable iff (!arst_n)
		done && value_class == CLASS_NAN |-> recip_class == CLASS_NAN
			&& reduced_num == '0 && reduced_den == '0)
		else $error("nan result inconsistent");

	a_inf_recip: assert property (@(posedge clk) disable iff (!arst_n)
		done && value_class == CLASS_INF |-> reduced_den == '0
			&& recip_class == CLASS_NORMAL && recip_num == '0 && recip_den != '0)
		else $error("infinite result inconsistent");

endmodule

bind fraction_reduce_classify frc_check u_frc_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.reduced_num (reduced_num),
	.reduced_den (reduced_den),
	.value_class (value_class),
	.recip_num   (recip_num),
	.recip_den   (recip_den),
	.recip_class (recip_class)
);

`default_nettype wire
